// ===== src/dlgi_pkg.sv =====
// Shared types and constants for the line gap interpolator.
`default_nettype none
package dlgi_pkg;
  localparam int MaxLine = 64;
  localparam int IdxW = $clog2(MaxLine);
  localparam int CntW = $clog2(MaxLine + 1);
  localparam int ValW = 16;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  typedef struct packed {
    logic [ValW-1:0] sample_value;
    logic            is_detector;
    logic            last_in_line;
  } in_item_t;

  typedef struct packed {
    logic [5:0]      position;
    logic [ValW-1:0] filled_value;
    logic            last_of_line;
  } out_item_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic [ValW-1:0] sample_value;
    logic            is_detector;
    logic            keep;
    logic            close;
  } cmd_t;
endpackage
`default_nettype wire

// ===== src/dlgi_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module dlgi_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/dlgi_front.sv =====
// Front end: counts line samples, marks dropped overflow items and line close.
`default_nettype none
module dlgi_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire dlgi_pkg::in_item_t in_i,
  input  wire logic              q_full_i,
  output      logic              busy_o,
  output      logic              push_o,
  output      dlgi_pkg::cmd_t    cmd_o
);
  logic [dlgi_pkg::CntW-1:0] cnt_q, cnt_d;
  assign busy_o = q_full_i;
  assign push_o = start_i && !q_full_i;
  always_comb begin
    cmd_o.sample_value = in_i.sample_value;
    cmd_o.is_detector  = in_i.is_detector;
    cmd_o.keep         = cnt_q < dlgi_pkg::CntW'(dlgi_pkg::MaxLine);
    cmd_o.close        = in_i.last_in_line;
    cnt_d = cnt_q;
    if (push_o) begin
      if (in_i.last_in_line) cnt_d = '0;
      else if (cmd_o.keep) cnt_d = cnt_q + 1'b1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
endmodule
`default_nettype wire

// ===== src/dlgi_queue.sv =====
// Short FIFO of classified commands between front and back ends.
`default_nettype none
module dlgi_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dlgi_pkg::cmd_t data_i,
  input  wire logic           pop_i,
  output      logic           full_o,
  output      logic           empty_o,
  output      dlgi_pkg::cmd_t data_o
);
  dlgi_pkg::cmd_t ent_q [dlgi_pkg::QDepth];
  logic [dlgi_pkg::QPtrW-1:0] wp_q, rp_q;
  logic [dlgi_pkg::QPtrW:0]   n_q;
  assign full_o  = n_q == (dlgi_pkg::QPtrW+1)'(dlgi_pkg::QDepth);
  assign empty_o = n_q == '0;
  assign data_o  = ent_q[rp_q];
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; n_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      n_q <= n_q + (dlgi_pkg::QPtrW+1)'(push_i) - (dlgi_pkg::QPtrW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ===== src/dlgi_back.sv =====
// Back end: stores the line, runs the three fill passes and emits the line.
`default_nettype none
module dlgi_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire dlgi_pkg::cmd_t     cmd_i,
  output      logic               pop_o,
  output      logic               valid_o,
  output      dlgi_pkg::out_item_t out_o
);
  localparam int IW = dlgi_pkg::IdxW;
  localparam int CW = dlgi_pkg::CntW;
  localparam int VW = dlgi_pkg::ValW;
  localparam int PW = VW + CW + 1;   // signed product width
  localparam int DW = IW + 1;        // divisor width

  typedef enum logic [3:0] {
    S_LOAD, S_SCAN, S_SCANW, S_HRD, S_HRDW, S_TRD, S_TRDW, S_GEN, S_DIV,
    S_NXT, S_NXTW, S_OUT, S_OUTW
  } st_e;
  typedef enum logic [1:0] { P_HEAD, P_TAIL, P_MID } pass_e;

  st_e st_q;
  pass_e pass_q;
  logic [CW-1:0] n_q, cnt_q, i_q, f_q, a_q, l_q;
  logic [IW:0]   len_q;
  logic          fnd_q;
  logic [VW-1:0] base_q, endv_q;
  logic signed [VW:0] dlt_q;
  // divider state
  logic [PW-1:0] rem_q, quo_q;
  logic [DW-1:0] div_q;
  logic [$clog2(PW+1)-1:0] dc_q;
  logic neg_q;

  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rv;
  logic wmark, rm;

  dlgi_ram #(.Width(VW), .Depth(dlgi_pkg::MaxLine)) u_val (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rv));
  dlgi_ram #(.Width(1), .Depth(dlgi_pkg::MaxLine)) u_mark (
    .clk_i, .we_i(we && st_q == S_LOAD), .waddr_i(waddr), .wdata_i(wmark),
    .raddr_i(raddr), .rdata_o(rm));

  assign pop_o = st_q == S_LOAD && !q_empty_i;

  logic [CW-1:0] ncl;
  logic [PW-1:0] qv;
  logic [PW:0]   trial;
  always_comb begin
    ncl = cnt_q + CW'(cmd_i.keep);
    raddr = i_q[IW-1:0];
    we = 1'b0; waddr = cnt_q[IW-1:0];
    wdata = cmd_i.sample_value; wmark = cmd_i.is_detector;
    qv = neg_q ? (~quo_q + 1'b1) : quo_q;
    trial = {rem_q, quo_q[PW-1]} - {{(PW+1-DW){1'b0}}, div_q};
    if (pop_o && cmd_i.keep) we = 1'b1;
    if (st_q == S_DIV && dc_q == '0) begin
      we = 1'b1; waddr = i_q[IW-1:0];
      wdata = (pass_q == P_MID) ? VW'(base_q + qv[VW-1:0]) : qv[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; cnt_q <= '0; valid_o <= 1'b0;
    end else begin
      valid_o <= st_q == S_OUTW;
      case (st_q)
        S_LOAD: if (pop_o) begin
          if (cmd_i.close) begin
            n_q <= ncl; cnt_q <= '0; i_q <= '0; f_q <= '0; fnd_q <= 1'b0;
            st_q <= (ncl == '0) ? S_LOAD : S_SCAN;
          end else begin
            cnt_q <= ncl;
          end
        end
        S_SCAN: st_q <= S_SCANW;
        S_SCANW: begin
          // find first detector
          if (rm) begin
            f_q <= i_q; i_q <= i_q; st_q <= (i_q == '0) ? S_NXT : S_HRD;
            a_q <= i_q; fnd_q <= 1'b1;
          end else if (i_q + 1'b1 == n_q) begin
            f_q <= '0; a_q <= '0; i_q <= '0; st_q <= S_NXT; fnd_q <= 1'b0;
          end else begin
            i_q <= i_q + 1'b1; st_q <= S_SCAN;
          end
        end
        S_HRD: st_q <= S_HRDW;       // reading v[f]
        S_HRDW: begin
          endv_q <= rv; pass_q <= P_HEAD; i_q <= '0; st_q <= S_GEN;
        end
        S_TRD: st_q <= S_TRDW;
        S_TRDW: begin
          endv_q <= rv; pass_q <= P_TAIL; i_q <= n_q - f_q; st_q <= S_GEN;
        end
        S_GEN: begin
          // set up product and divisor for position i_q
          dc_q <= ($clog2(PW+1))'(PW);
          rem_q <= '0;
          case (pass_q)
            P_HEAD: begin
              quo_q <= PW'(endv_q) * PW'(i_q); div_q <= DW'(f_q); neg_q <= 1'b0;
            end
            P_TAIL: begin
              quo_q <= PW'(endv_q) * PW'(n_q - 1'b1 - i_q);
              div_q <= DW'(f_q); neg_q <= 1'b0;
            end
            default: begin
              neg_q <= dlt_q[VW];
              quo_q <= PW'(dlt_q[VW] ? -dlt_q : dlt_q) * PW'(i_q - a_q);
              div_q <= DW'(len_q);
            end
          endcase
          st_q <= S_DIV;
        end
        S_DIV: begin
          if (dc_q != '0) begin
            dc_q <= dc_q - 1'b1;
            if (!trial[PW]) begin
              rem_q <= trial[PW-1:0]; quo_q <= {quo_q[PW-2:0], 1'b1};
            end else begin
              rem_q <= {rem_q[PW-2:0], quo_q[PW-1]}; quo_q <= {quo_q[PW-2:0], 1'b0};
            end
          end else begin
            case (pass_q)
              P_HEAD: if (i_q + 1'b1 == f_q) begin
                i_q <= n_q - 1'b1 - f_q; st_q <= S_TRD;
              end else begin
                i_q <= i_q + 1'b1; st_q <= S_GEN;
              end
              P_TAIL: if (i_q + 1'b1 == n_q) begin
                i_q <= f_q; a_q <= f_q; st_q <= S_NXT;
              end else begin
                i_q <= i_q + 1'b1; st_q <= S_GEN;
              end
              default: if (i_q + 1'b1 == l_q) begin
                i_q <= l_q; a_q <= l_q; st_q <= S_NXT;
              end else begin
                i_q <= i_q + 1'b1; st_q <= S_GEN;
              end
            endcase
          end
        end
        S_NXT: st_q <= S_NXTW;
        S_NXTW: begin
          // walk from anchor a_q; read value at anchor first, then find next mark
          if (i_q == a_q) begin
            if (rm) begin
              base_q <= rv; fnd_q <= 1'b1;
            end else fnd_q <= 1'b0;
            if (a_q + 1'b1 >= n_q) begin
              i_q <= '0; st_q <= S_OUT;
            end else begin
              i_q <= i_q + 1'b1; st_q <= S_NXT;
            end
          end else if (rm && fnd_q) begin
            l_q <= i_q; len_q <= (IW+1)'(i_q - a_q);
            dlt_q <= $signed({1'b0, rv}) - $signed({1'b0, base_q});
            pass_q <= P_MID;
            if (i_q == a_q + 1'b1) begin
              a_q <= i_q; st_q <= S_NXT;
            end else begin
              i_q <= a_q + 1'b1; st_q <= S_GEN;
            end
          end else if (rm) begin
            a_q <= i_q; st_q <= S_NXT;
          end else if (i_q + 1'b1 == n_q) begin
            i_q <= '0; st_q <= S_OUT;
          end else begin
            i_q <= i_q + 1'b1; st_q <= S_NXT;
          end
        end
        S_OUT: st_q <= S_OUTW;
        S_OUTW: begin
          out_o.position <= 6'(i_q);
          out_o.filled_value <= rv;
          out_o.last_of_line <= i_q + 1'b1 == n_q;
          if (i_q + 1'b1 == n_q) st_q <= S_LOAD;
          else begin
            i_q <= i_q + 1'b1; st_q <= S_OUT;
          end
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/detector_line_gap_interpolator_top.sv =====
// Top level of the detector line gap interpolator.
`default_nettype none
// Usage:
//  - Input channel: drive in_i and raise start_i; a transfer happens at a
//    clock edge with start_i high and busy_o low. One sample per transfer;
//    last_in_line closes the line. Samples past MaxLine are dropped, but
//    their close mark still counts.
//  - Result channel: done_o strobes for one cycle per result; the receiver
//    cannot hold results off. A closed line yields one result per kept sample.
//  - Samples can be loaded back to back while the back end is free; a
//    four-entry command queue absorbs samples of the next line while a line
//    is filled and emitted.
//  - Fill time is set by the bit-serial restoring divider in the back end,
//    which runs once per filled position, plus the detector search over the
//    scanned positions and the emission of each result.
//  - Reset clears the sample count, the queue and the sequencer; the line
//    store has no reset and is always written before it is read.
module detector_line_gap_interpolator_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire dlgi_pkg::in_item_t  in_i,
  output      logic                busy_o,
  output      logic                done_o,
  output      dlgi_pkg::out_item_t out_o
);
  logic push, pop, full, empty;
  dlgi_pkg::cmd_t cmd_in, cmd_out;

  // Classify: count the line, mark drops and close.
  dlgi_front u_front (
    .clk_i, .rst_ni, .start_i, .in_i, .q_full_i(full),
    .busy_o, .push_o(push), .cmd_o(cmd_in));

  // Decouple load from fill and emission.
  dlgi_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(cmd_in), .pop_i(pop),
    .full_o(full), .empty_o(empty), .data_o(cmd_out));

  // Store, fill and emit.
  dlgi_back u_back (
    .clk_i, .rst_ni, .q_empty_i(empty), .cmd_i(cmd_out), .pop_o(pop),
    .valid_o(done_o), .out_o);
endmodule
`default_nettype wire

// ===== src/detector_line_gap_interpolator_chk.sv =====
// Port-level checker for the line gap interpolator, bound to the top level.
`default_nettype none
module detector_line_gap_interpolator_chk (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                busy_o,
  input wire logic                done_o,
  input wire dlgi_pkg::out_item_t out_o
);
  a_first_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !$past(done_o) && !$past(done_o, 2) |-> out_o.position == 6'd0)
    else $error("line does not start at position zero");
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !out_o.last_of_line |-> ##2 done_o && out_o.position == $past(out_o.position, 2) + 6'd1)
    else $error("positions not consecutive");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results closer than two cycles");
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !done_o && !busy_o)
    else $error("result or busy during reset");
endmodule
bind detector_line_gap_interpolator_top detector_line_gap_interpolator_chk u_chk (
  .clk_i, .rst_ni, .busy_o, .done_o, .out_o);
`default_nettype wire
